// ===== design/ptrmx_pkg.sv =====
// ----------------------------------------------------------------------------
// ptrmx_pkg
// Shared codes for the persistent trie range max-XOR block.
// ----------------------------------------------------------------------------
package ptrmx_pkg;

  localparam int unsigned STATUS_W = 2;

  // transaction kinds
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

// ===== design/persistent_trie_range_max_xor_top.sv =====
// ----------------------------------------------------------------------------
// persistent_trie_range_max_xor_top
// Persistent binary trie over running XOR prefixes, answering range max-XOR.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. An append sets up at acceptance, then
// does one node-store read-modify-write per trie level (VALUE_BITS levels),
// writes the leaf and registers the result. A query walks the two versions
// together through the two read ports of the node store: the top level passes
// through the root-node read, the fetch of the opposite children and the compare;
// a lower level needs only the compare when the level above took the opposite
// branch, and the fetch as well when it fell back to the same-bit branch, since
// those children must then be fetched. Errored transactions go straight to
// registering the result.
// The next transaction is accepted while a result still waits at the output.
// Node store and root table have no reset and no clearing pass.
module persistent_trie_range_max_xor_top #(
  parameter int unsigned VALUE_BITS  = 24,
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  operation_i,
  input  logic [VALUE_BITS-1:0]                 append_value_i,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]      low_index_i,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]      high_index_i,
  input  logic [VALUE_BITS-1:0]                 query_key_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [VALUE_BITS-1:0]                 max_xor_o,
  output logic [ptrmx_pkg::STATUS_W-1:0]        status_o
);

  localparam int unsigned IDX_W      = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned NODE_DEPTH = MAX_ENTRIES * (VALUE_BITS + 1);
  localparam int unsigned NODE_W     = $clog2(NODE_DEPTH);
  localparam int unsigned NFW        = $clog2(NODE_DEPTH + 1);
  localparam int unsigned CNT_W      = IDX_W;
  localparam int unsigned NODE_BITS  = 2 * NODE_W + CNT_W;
  localparam int unsigned C0_LSB     = CNT_W;
  localparam int unsigned C1_LSB     = CNT_W + NODE_W;
  localparam int unsigned LVL_W      = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned ROOT_DEPTH = MAX_ENTRIES + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_APPEND = 3'd1;
  localparam logic [2:0] S_ALAST  = 3'd2;
  localparam logic [2:0] S_QROOT  = 3'd3;
  localparam logic [2:0] S_QCUR   = 3'd4;
  localparam logic [2:0] S_QOPP   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  // memories
  logic [NODE_BITS-1:0] node_mem [NODE_DEPTH];
  logic [NODE_W-1:0]    root_mem [ROOT_DEPTH];

  logic [NODE_BITS-1:0] rd_a_q, rd_b_q;
  logic                 nz_a_q, nz_b_q;
  logic [NODE_W-1:0]    rt_a_q, rt_b_q;
  logic                 rnz_a_q, rnz_b_q;

  logic [NODE_W-1:0]    node_ra, node_rb, node_wa;
  logic [NODE_BITS-1:0] node_wd;
  logic                 node_we;
  logic [IDX_W-1:0]     root_ra, root_rb, root_wa;
  logic                 root_we;

  // control and architectural state
  logic [2:0]            state_q, state_d;
  logic [IDX_W-1:0]      ent_cnt_q, ent_cnt_d;
  logic [VALUE_BITS-1:0] prefix_q, prefix_d;
  logic [NFW-1:0]        next_free_q, next_free_d;
  logic [NODE_W-1:0]     last_root_q, last_root_d;
  logic [VALUE_BITS-1:0] key_q, key_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;
  logic [NODE_W-1:0]     y_q, y_d;
  logic [NODE_W-1:0]     at_q, at_d, bt_q, bt_d;
  logic [VALUE_BITS-1:0] best_q, best_d;
  logic [ptrmx_pkg::STATUS_W-1:0] res_st_q, res_st_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] max_xor_q, max_xor_d;
  logic [ptrmx_pkg::STATUS_W-1:0] status_q, status_d;

  // node 0 and root entry 0 are the null node and read as zero
  logic [NODE_BITS-1:0] nd_a, nd_b;
  logic [NODE_W-1:0]    rt_a, rt_b;
  logic [NODE_W-1:0]    a_c0, a_c1, b_c0, b_c1;
  logic [CNT_W-1:0]     a_cnt, b_cnt;
  logic                 kbit, kbit_dn;
  logic [LVL_W-1:0]     lvl_dn;
  logic [NODE_W-1:0]    y_inc;
  logic [NFW:0]         nf_need;
  logic                 store_full, bad_range, accept;

  assign nd_a  = nz_a_q ? rd_a_q : '0;
  assign nd_b  = nz_b_q ? rd_b_q : '0;
  assign rt_a  = rnz_a_q ? rt_a_q : '0;
  assign rt_b  = rnz_b_q ? rt_b_q : '0;
  assign a_c0  = nd_a[C0_LSB +: NODE_W];
  assign a_c1  = nd_a[C1_LSB +: NODE_W];
  assign b_c0  = nd_b[C0_LSB +: NODE_W];
  assign b_c1  = nd_b[C1_LSB +: NODE_W];
  assign a_cnt = nd_a[CNT_W-1:0];
  assign b_cnt = nd_b[CNT_W-1:0];

  assign lvl_dn  = lvl_q - LVL_W'(1);
  assign kbit    = key_q[lvl_q];
  assign kbit_dn = key_q[lvl_dn];
  assign y_inc   = y_q + NODE_W'(1);

  assign nf_need    = {1'b0, next_free_q} + (NFW+1)'(VALUE_BITS + 1);
  assign store_full = (ent_cnt_q >= IDX_W'(MAX_ENTRIES)) ||
                      (nf_need > (NFW+1)'(NODE_DEPTH));
  assign bad_range  = (low_index_i == '0) || (low_index_i > high_index_i) ||
                      (high_index_i > ent_cnt_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign max_xor_o   = max_xor_q;
  assign status_o    = status_q;

  always_comb begin
    state_d     = state_q;
    ent_cnt_d   = ent_cnt_q;
    prefix_d    = prefix_q;
    next_free_d = next_free_q;
    last_root_d = last_root_q;
    key_d       = key_q;
    lvl_d       = lvl_q;
    y_d         = y_q;
    at_d        = at_q;
    bt_d        = bt_q;
    best_d      = best_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    max_xor_d   = max_xor_q;
    status_d    = status_q;

    node_ra = '0;
    node_rb = '0;
    node_we = 1'b0;
    node_wa = y_q;
    node_wd = '0;
    root_ra = low_index_i - IDX_W'(1);
    root_rb = high_index_i;
    root_wa = ent_cnt_q + IDX_W'(1);
    root_we = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          best_d = '0;
          lvl_d  = LVL_W'(VALUE_BITS - 1);
          if (operation_i == ptrmx_pkg::OP_APPEND) begin
            if (store_full) begin
              res_st_d = ptrmx_pkg::ST_FULL;
              state_d  = S_DONE;
            end else begin
              // all VALUE_BITS+1 nodes of the new path are taken at once
              prefix_d    = prefix_q ^ append_value_i;
              key_d       = prefix_q ^ append_value_i;
              y_d         = NODE_W'(next_free_q);
              next_free_d = NFW'(nf_need);
              last_root_d = NODE_W'(next_free_q);
              root_we     = 1'b1;
              ent_cnt_d   = ent_cnt_q + IDX_W'(1);
              node_ra     = last_root_q;
              res_st_d    = ptrmx_pkg::ST_OK;
              state_d     = S_APPEND;
            end
          end else begin
            if (bad_range) begin
              res_st_d = ptrmx_pkg::ST_RANGE;
              state_d  = S_DONE;
            end else begin
              key_d    = prefix_q ^ query_key_i;
              res_st_d = ptrmx_pkg::ST_OK;
              state_d  = S_QROOT;
            end
          end
        end
      end

      S_APPEND: begin
        // copy the old node, bump its count, point the taken branch forward
        node_we = 1'b1;
        node_wd = {(kbit ? y_inc : a_c1), (kbit ? a_c0 : y_inc), a_cnt + CNT_W'(1)};
        node_ra = kbit ? a_c1 : a_c0;
        y_d     = y_inc;
        if (lvl_q == '0) begin
          state_d = S_ALAST;
        end else begin
          lvl_d = lvl_dn;
        end
      end

      S_ALAST: begin
        node_we = 1'b1;
        node_wd = {{(2*NODE_W){1'b0}}, a_cnt + CNT_W'(1)};
        state_d = S_DONE;
      end

      S_QROOT: begin
        node_ra = rt_a;
        node_rb = rt_b;
        state_d = S_QCUR;
      end

      S_QCUR: begin
        // fetch the opposite children, keep the same-bit ones as fallback
        node_ra = kbit ? a_c0 : a_c1;
        node_rb = kbit ? b_c0 : b_c1;
        at_d    = kbit ? a_c1 : a_c0;
        bt_d    = kbit ? b_c1 : b_c0;
        state_d = S_QOPP;
      end

      S_QOPP: begin
        if (b_cnt != a_cnt) begin
          best_d[lvl_q] = 1'b1;
          if (lvl_q == '0) begin
            state_d = S_DONE;
          end else begin
            // the opposite pair is the new current pair, its data is in hand
            lvl_d   = lvl_dn;
            node_ra = kbit_dn ? a_c0 : a_c1;
            node_rb = kbit_dn ? b_c0 : b_c1;
            at_d    = kbit_dn ? a_c1 : a_c0;
            bt_d    = kbit_dn ? b_c1 : b_c0;
          end
        end else begin
          if (lvl_q == '0) begin
            state_d = S_DONE;
          end else begin
            lvl_d   = lvl_dn;
            node_ra = at_q;
            node_rb = bt_q;
            state_d = S_QCUR;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          max_xor_d   = (res_st_q == ptrmx_pkg::ST_OK) ? best_q : '0;
          status_d    = res_st_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    rd_a_q <= node_mem[node_ra];
    rd_b_q <= node_mem[node_rb];
    nz_a_q <= (node_ra != '0);
    nz_b_q <= (node_rb != '0);
  end

  always_ff @(posedge clk_i) begin
    if (root_we) begin
      root_mem[root_wa] <= last_root_d;
    end
    rt_a_q  <= root_mem[root_ra];
    rt_b_q  <= root_mem[root_rb];
    rnz_a_q <= (root_ra != '0);
    rnz_b_q <= (root_rb != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ent_cnt_q   <= '0;
      prefix_q    <= '0;
      next_free_q <= NFW'(1);
      last_root_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ent_cnt_q   <= ent_cnt_d;
      prefix_q    <= prefix_d;
      next_free_q <= next_free_d;
      last_root_q <= last_root_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    lvl_q     <= lvl_d;
    y_q       <= y_d;
    at_q      <= at_d;
    bt_q      <= bt_d;
    best_q    <= best_d;
    res_st_q  <= res_st_d;
    max_xor_q <= max_xor_d;
    status_q  <= status_d;
  end

  // assertions
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second transaction taken while one is in flight");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ptrmx_pkg::ST_OK)) |-> (max_xor_o == '0))
    else $error("errored result carries a nonzero value");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_cnt_q <= IDX_W'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  a_alloc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(ent_cnt_q) |->
      ({1'b0, next_free_q} == {1'b0, $past(next_free_q)} + (NFW+1)'(VALUE_BITS + 1)))
    else $error("node allocation out of step with entry count");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the persistent trie range max-XOR block. A directed
// table of appends and queries (bad ranges, extreme values) is followed by
// random traffic under three idling mixes and a few whole-table queries.
// Marked directed rows use typed-in expectations; the rest are checked by a
// brute-force model of the running prefixes that scans for the best XOR.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned VB          = 24;
  localparam int unsigned ME          = 4096;
  localparam int unsigned IW          = $clog2(ME + 1);
  localparam int unsigned NODE_DEPTH  = ME * (VB + 1);
  localparam int unsigned WDOG_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES = 500;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS = 430;
  localparam int unsigned N_DIR       = 21;

  typedef struct packed {
    logic [VB-1:0]                  mx;
    logic [ptrmx_pkg::STATUS_W-1:0] st;
  } result_t;

  typedef struct packed {
    logic                           op;
    logic [VB-1:0]                  val;
    logic [IW-1:0]                  lo;
    logic [IW-1:0]                  hi;
    logic [VB-1:0]                  key;
    logic                           chk;   // expectation typed in below
    logic [VB-1:0]                  emx;
    logic [ptrmx_pkg::STATUS_W-1:0] est;
  } stim_row_t;

  localparam stim_row_t DIR_TAB [N_DIR] = '{
    // nothing stored yet
    '{ptrmx_pkg::OP_QUERY,  24'h0, 13'd1, 13'd1, 24'h0,
      1'b1, 24'h0, ptrmx_pkg::ST_RANGE},
    '{ptrmx_pkg::OP_APPEND, 24'h0, 13'd0, 13'd0, 24'h0,
      1'b1, 24'h0, ptrmx_pkg::ST_OK},
    '{ptrmx_pkg::OP_APPEND, 24'hFFFFFF, 13'd0, 13'd0, 24'h0,
      1'b1, 24'h0, ptrmx_pkg::ST_OK},
    '{ptrmx_pkg::OP_QUERY,  24'h0, 13'd1, 13'd1, 24'h0,
      1'b1, 24'hFFFFFF, ptrmx_pkg::ST_OK},
    '{ptrmx_pkg::OP_QUERY,  24'h0, 13'd2, 13'd2, 24'h0,
      1'b1, 24'h0, ptrmx_pkg::ST_OK},
    '{ptrmx_pkg::OP_QUERY,  24'h0, 13'd1, 13'd2, 24'hFFFFFF,
      1'b1, 24'hFFFFFF, ptrmx_pkg::ST_OK},
    // low index zero, crossed range, past the end, all-ones indices
    '{ptrmx_pkg::OP_QUERY,  24'h0, 13'd0, 13'd1, 24'h0,
      1'b1, 24'h0, ptrmx_pkg::ST_RANGE},
    '{ptrmx_pkg::OP_QUERY,  24'h0, 13'd2, 13'd1, 24'h0,
      1'b1, 24'h0, ptrmx_pkg::ST_RANGE},
    '{ptrmx_pkg::OP_QUERY,  24'h0, 13'd1, 13'd3, 24'h0,
      1'b1, 24'h0, ptrmx_pkg::ST_RANGE},
    '{ptrmx_pkg::OP_QUERY,  24'hFFFFFF, 13'd8191, 13'd8191, 24'hFFFFFF,
      1'b1, 24'h0, ptrmx_pkg::ST_RANGE},
    '{ptrmx_pkg::OP_QUERY,  24'h0, 13'd1, 13'd8191, 24'h0,
      1'b1, 24'h0, ptrmx_pkg::ST_RANGE},
    '{ptrmx_pkg::OP_APPEND, 24'hFFFFFF, 13'd8191, 13'd8191, 24'hFFFFFF,
      1'b1, 24'h0, ptrmx_pkg::ST_OK},
    '{ptrmx_pkg::OP_APPEND, 24'h800000, 13'd0, 13'd0, 24'h0,
      1'b1, 24'h0, ptrmx_pkg::ST_OK},
    '{ptrmx_pkg::OP_APPEND, 24'h000001, 13'd0, 13'd0, 24'h0,
      1'b1, 24'h0, ptrmx_pkg::ST_OK},
    '{ptrmx_pkg::OP_QUERY,  24'h0, 13'd3, 13'd5, 24'h555555,
      1'b0, 24'h0, ptrmx_pkg::ST_OK},
    '{ptrmx_pkg::OP_QUERY,  24'h0, 13'd1, 13'd5, 24'hAAAAAA,
      1'b0, 24'h0, ptrmx_pkg::ST_OK},
    '{ptrmx_pkg::OP_APPEND, 24'h5A5A5A, 13'd0, 13'd0, 24'h0,
      1'b1, 24'h0, ptrmx_pkg::ST_OK},
    '{ptrmx_pkg::OP_APPEND, 24'hA5A5A5, 13'd0, 13'd0, 24'h0,
      1'b1, 24'h0, ptrmx_pkg::ST_OK},
    '{ptrmx_pkg::OP_QUERY,  24'h0, 13'd4, 13'd4, 24'h0,
      1'b0, 24'h0, ptrmx_pkg::ST_OK},
    '{ptrmx_pkg::OP_QUERY,  24'h0, 13'd1, 13'd7, 24'hFFFFFF,
      1'b0, 24'h0, ptrmx_pkg::ST_OK},
    '{ptrmx_pkg::OP_QUERY,  24'h0, 13'd7, 13'd7, 24'h123456,
      1'b0, 24'h0, ptrmx_pkg::ST_OK}
  };

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic                           op;
  logic [VB-1:0]                  append_value;
  logic [IW-1:0]                  low_index;
  logic [IW-1:0]                  high_index;
  logic [VB-1:0]                  query_key;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [VB-1:0]                  max_xor;
  logic [ptrmx_pkg::STATUS_W-1:0] status;

  // model state: stored prefixes by position, running prefix, node usage
  logic [VB-1:0] prefix_at [0:ME];
  logic [VB-1:0] run_prefix = '0;
  int unsigned   n_entries  = 0;
  int unsigned   free_node  = 1;

  result_t       pending_results [$];
  int unsigned   n_err = 0;
  int unsigned   n_app = 0, n_full = 0, n_qry = 0, n_bad = 0, n_checked = 0;
  int unsigned   src_idle_pct = 0, snk_idle_pct = 0;
  bit            hold_req = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   stall_cycles = 0;

  persistent_trie_range_max_xor_top #(
    .VALUE_BITS  (VB),
    .MAX_ENTRIES (ME)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (op),
    .append_value_i (append_value),
    .low_index_i    (low_index),
    .high_index_i   (high_index),
    .query_key_i    (query_key),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .max_xor_o      (max_xor),
    .status_o       (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit store_full();
    return (n_entries >= ME) || (free_node + VB + 1 > NODE_DEPTH);
  endfunction

  // best of (prefix XOR running prefix XOR key) over positions lo..hi
  function automatic result_t predict_max_xor(input logic op_v, input logic [VB-1:0] val,
                                               input logic [IW-1:0] lo, input logic [IW-1:0] hi,
                                               input logic [VB-1:0] key);
    result_t       r;
    logic [VB-1:0] k;
    int unsigned   p;
    r.mx = '0;
    r.st = ptrmx_pkg::ST_OK;
    if (op_v == ptrmx_pkg::OP_APPEND) begin
      if (store_full()) begin
        r.st = ptrmx_pkg::ST_FULL;
        n_full++;
      end else begin
        run_prefix = run_prefix ^ val;
        n_entries++;
        prefix_at[n_entries] = run_prefix;
        free_node += VB + 1;
        n_app++;
      end
    end else if (lo < 1 || lo > hi || hi > n_entries) begin
      r.st = ptrmx_pkg::ST_RANGE;
      n_bad++;
    end else begin
      k = run_prefix ^ key;
      for (p = lo; p <= hi; p++) begin
        if ((prefix_at[p] ^ k) > r.mx) r.mx = prefix_at[p] ^ k;
      end
      n_qry++;
    end
    return r;
  endfunction

  // holds valid until the transaction is taken, then logs what it should give
  task automatic send_txn(input logic op_v, input logic [VB-1:0] val,
                          input logic [IW-1:0] lo, input logic [IW-1:0] hi,
                          input logic [VB-1:0] key, input bit chk,
                          input logic [VB-1:0] emx,
                          input logic [ptrmx_pkg::STATUS_W-1:0] est);
    result_t r;
    in_valid     <= 1'b1;
    op           <= op_v;
    append_value <= val;
    low_index    <= lo;
    high_index   <= hi;
    query_key    <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_max_xor(op_v, val, lo, hi, key);
    if (chk) begin
      r.mx = emx;
      r.st = est;
    end
    pending_results.push_back(r);
  endtask

  task automatic source_gap();
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VB-1:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return VB'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic [IW-1:0] lo, hi;
    int unsigned   pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      send_txn(ptrmx_pkg::OP_APPEND, rand_word(), IW'($urandom), IW'($urandom),
               VB'($urandom), 1'b0, '0, ptrmx_pkg::ST_OK);
    end else if (pick < 93) begin
      hi = IW'($urandom_range(1, n_entries));
      case ($urandom_range(3))
        0:       lo = IW'(1);
        1:       lo = hi;
        default: lo = IW'($urandom_range(1, hi));
      endcase
      if ($urandom_range(3) == 0) hi = IW'(n_entries);
      send_txn(ptrmx_pkg::OP_QUERY, VB'($urandom), lo, hi, rand_word(), 1'b0, '0,
               ptrmx_pkg::ST_OK);
    end else begin
      // broken ranges: anything over the whole index space, mostly invalid
      lo = IW'($urandom);
      hi = IW'($urandom);
      if ($urandom_range(1) == 0) lo = '0;
      send_txn(ptrmx_pkg::OP_QUERY, VB'($urandom), lo, hi, VB'($urandom), 1'b0, '0,
               ptrmx_pkg::ST_OK);
    end
  endtask

  // result checker and receiver backpressure
  task automatic check_result(input logic [VB-1:0] mx,
                              input logic [ptrmx_pkg::STATUS_W-1:0] st);
    result_t e;
    if (pending_results.size() == 0) begin
      n_err++;
      $display("%0t: unexpected transaction max_xor=%h status=%0d", $time, mx, st);
    end else begin
      e = pending_results.pop_front();
      n_checked++;
      if (mx !== e.mx) begin
        n_err++;
        $display("%0t: max_xor mismatch expected %h actual %h", $time, e.mx, mx);
      end
      if (st !== e.st) begin
        n_err++;
        $display("%0t: status mismatch expected %0d actual %0d", $time, e.st, st);
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) check_result(max_xor, status);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  initial begin
    int unsigned ph, k;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    op           = ptrmx_pkg::OP_APPEND;
    append_value = '0;
    low_index    = '0;
    high_index   = '0;
    query_key    = '0;
    src_idle_pct = 28;
    snk_idle_pct = 67;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < N_DIR; k++) begin
      send_txn(DIR_TAB[k].op, DIR_TAB[k].val, DIR_TAB[k].lo, DIR_TAB[k].hi,
               DIR_TAB[k].key, DIR_TAB[k].chk, DIR_TAB[k].emx, DIR_TAB[k].est);
      source_gap();
    end

    for (ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 67 : 0;
      snk_idle_pct = (ph == 0) ? 67 : (ph == 1) ? 28 : 0;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // long receiver hold while the source keeps pushing
        if (ph == 0 && k == 150) hold_req = 1'b1;
        send_random();
        if (ph == 1 && k == 200) drain_results();
        else source_gap();
      end
    end

    // probe the whole table and just past its end, then a last random burst
    send_txn(ptrmx_pkg::OP_QUERY, '0, IW'(1), IW'(n_entries), rand_word(), 1'b0, '0,
             ptrmx_pkg::ST_OK);
    send_txn(ptrmx_pkg::OP_QUERY, '0, IW'(n_entries), IW'(n_entries), rand_word(), 1'b0,
             '0, ptrmx_pkg::ST_OK);
    send_txn(ptrmx_pkg::OP_QUERY, '0, IW'(1), IW'(n_entries + 1), '0, 1'b1, '0,
             ptrmx_pkg::ST_RANGE);
    for (k = 0; k < 20; k++) send_random();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d appends, %0d refused on a full store, %0d range queries,",
             n_app, n_full, n_qry);
    $display("%0d bad ranges; %0d results checked, trie reached %0d entries.",
             n_bad, n_checked, n_entries);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ptrmx_pkg.sv
design/persistent_trie_range_max_xor_top.sv
dv/tb_top.sv
